@@ rtl/keymap_dead_key_utf8_translator_assert.svh @@
// Assertion macros for the keymap dead-key translator.
// Included by the top level; depends on nothing.
`ifndef KEYMAP_DEAD_KEY_UTF8_TRANSLATOR_ASSERT_SVH
`define KEYMAP_DEAD_KEY_UTF8_TRANSLATOR_ASSERT_SVH

// same-cycle implication
`define KDU_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define KDU_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/kdu_pkg.sv @@
// Shared types, constants and the UTF-8 encoder of the keymap translator.
// Depends on nothing.
package kdu_pkg;

	localparam int MOD_PLANES = 16;

	localparam logic [1:0] KIND_KEY = 2'd0;
	localparam logic [1:0] KIND_MAP = 2'd1;
	localparam logic [1:0] KIND_DIA = 2'd2;

	localparam logic [1:0] COL_DEAD = 2'd0;
	localparam logic [1:0] COL_BASE = 2'd1;
	localparam logic [1:0] COL_RES  = 2'd2;

	localparam logic [3:0] PL_SHIFT = 4'd1;

	localparam int BIT_CAPS = 21;
	localparam int BIT_NPAD = 22;
	localparam int BIT_DEAD = 23;

	localparam logic [20:0] CP_SPACE   = 21'h20;
	localparam logic [20:0] CP_1B_MAX  = 21'h7F;
	localparam logic [20:0] CP_2B_MAX  = 21'h7FF;
	localparam logic [20:0] CP_SUR_LO  = 21'hD800;
	localparam logic [20:0] CP_SUR_HI  = 21'hDFFF;
	localparam logic [20:0] CP_3B_MAX  = 21'hFFFF;
	localparam logic [20:0] CP_MAX     = 21'h10FFFF;

	localparam logic [7:0] LEAD_2B = 8'hC0;
	localparam logic [7:0] LEAD_3B = 8'hE0;
	localparam logic [7:0] LEAD_4B = 8'hF0;
	localparam logic [7:0] CONT_B  = 8'h80;

	typedef struct packed {
		logic [1:0]  kind;
		logic [6:0]  key_code;
		logic        released;
		logic        shift_down;
		logic        ctrl_down;
		logic        alt_down;
		logic        altgr_down;
		logic        caps_lock_on;
		logic        num_lock_on;
		logic [3:0]  table_plane;
		logic [6:0]  table_slot;
		logic [23:0] table_word;
	} kdu_in_t;

	typedef struct packed {
		logic [7:0] utf8_byte;
		logic       last_byte;
	} kdu_out_t;

	typedef struct packed {
		logic [20:0] dead;
		logic [20:0] base;
		logic [20:0] res;
	} kdu_dia_row_t;

	typedef struct packed {
		logic        clr;
		logic        app;
		logic        start;
		logic [20:0] cp;
	} kdu_obuf_ctl_t;

	typedef struct packed {
		logic [2:0]      len;
		logic [3:0][7:0] b;
	} kdu_enc_t;

	function automatic kdu_enc_t kdu_utf8_enc(input logic [20:0] cp);
		kdu_enc_t e;
		e = '0;
		if (cp == '0) begin
			e.len = 3'd0;
		end else if (cp <= CP_1B_MAX) begin
			e.len  = 3'd1;
			e.b[0] = cp[7:0];
		end else if (cp <= CP_2B_MAX) begin
			e.len  = 3'd2;
			e.b[0] = LEAD_2B | {3'b0, cp[10:6]};
			e.b[1] = CONT_B | {2'b0, cp[5:0]};
		end else if (cp >= CP_SUR_LO && cp <= CP_SUR_HI) begin
			e.len = 3'd0;
		end else if (cp <= CP_3B_MAX) begin
			e.len  = 3'd3;
			e.b[0] = LEAD_3B | {4'b0, cp[15:12]};
			e.b[1] = CONT_B | {2'b0, cp[11:6]};
			e.b[2] = CONT_B | {2'b0, cp[5:0]};
		end else if (cp <= CP_MAX) begin
			e.len  = 3'd4;
			e.b[0] = LEAD_4B | {5'b0, cp[20:18]};
			e.b[1] = CONT_B | {2'b0, cp[17:12]};
			e.b[2] = CONT_B | {2'b0, cp[11:6]};
			e.b[3] = CONT_B | {2'b0, cp[5:0]};
		end
		return e;
	endfunction

endpackage

@@ rtl/kdu_chan_if.sv @@
// Valid/ready channel carrying one item of a given payload type.
// Depends on nothing.
interface kdu_chan_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ rtl/kdu_keymap.sv @@
// Keymap word memory: one write port, one registered read port.
// Depends on nothing.
module kdu_keymap #(
	parameter int DEPTH = 2048,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [23:0]   wdata,
	input  logic [AW-1:0] raddr,
	output logic [23:0]   rdata
);
	logic [23:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ rtl/kdu_diac.sv @@
// Diacritic table: dead, base and result columns, row read registered.
// Depends on kdu_pkg.
module kdu_diac #(
	parameter int ENTRIES = 64,
	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic                 wall,
	input  logic [1:0]           wcol,
	input  logic [IW-1:0]        waddr,
	input  logic [20:0]          wdata,
	input  logic [IW-1:0]        raddr,
	output kdu_pkg::kdu_dia_row_t rdata
);
	import kdu_pkg::*;

	logic [20:0] dead_mem [ENTRIES];
	logic [20:0] base_mem [ENTRIES];
	logic [20:0] res_mem  [ENTRIES];

	always_ff @(posedge clk) begin
		if (we && (wall || wcol == COL_DEAD)) begin
			dead_mem[waddr] <= wdata;
		end
		if (we && (wall || wcol == COL_BASE)) begin
			base_mem[waddr] <= wdata;
		end
		if (we && (wall || wcol == COL_RES)) begin
			res_mem[waddr] <= wdata;
		end
		rdata.dead <= dead_mem[raddr];
		rdata.base <= base_mem[raddr];
		rdata.res  <= res_mem[raddr];
	end
endmodule

@@ rtl/kdu_obuf.sv @@
// Byte buffer: encodes code points to UTF-8, then drains one byte per item.
// Depends on kdu_pkg and kdu_chan_if.
module kdu_obuf (
	input  logic                  clk,
	input  logic                  arst_n,
	input  kdu_pkg::kdu_obuf_ctl_t ctl,
	output logic                  busy,
	kdu_chan_if.source            out_ch
);
	import kdu_pkg::*;

	logic [7:0] obyte_q [8];
	logic [3:0] cnt_q;
	logic [2:0] rd_q;
	logic       drain_q;
	logic       ov_q;
	kdu_out_t   od_q;
	kdu_enc_t   enc;
	logic       load;
	logic       at_last;
	logic [3:0] off [8];

	assign enc     = kdu_utf8_enc(ctl.cp);
	assign load    = drain_q && (!ov_q || out_ch.ready);
	assign at_last = ({1'b0, rd_q} == (cnt_q - 4'd1));
	assign busy    = drain_q;
	assign out_ch.valid = ov_q;
	assign out_ch.data  = od_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			rd_q    <= '0;
			drain_q <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			if (ctl.clr) begin
				cnt_q <= '0;
			end else if (ctl.app) begin
				cnt_q <= cnt_q + {1'b0, enc.len};
			end
			if (ctl.start) begin
				rd_q    <= '0;
				drain_q <= (cnt_q != '0);
			end else if (load) begin
				rd_q <= rd_q + 3'd1;
				if (at_last) begin
					drain_q <= 1'b0;
				end
			end
			if (load) begin
				ov_q <= 1'b1;
			end else if (out_ch.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			od_q.utf8_byte <= obyte_q[rd_q];
			od_q.last_byte <= at_last;
		end
	end

	always_comb begin
		for (int j = 0; j < 8; j++) begin
			off[j] = 4'(j) - cnt_q;
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < 8; j++) begin
			if (ctl.app && off[j] < {1'b0, enc.len}) begin
				obyte_q[j] <= enc.b[off[j][1:0]];
			end
		end
	end
endmodule

@@ rtl/keymap_dead_key_utf8_translator.sv @@
// Keymap dead-key translator: key events to UTF-8 bytes.
// Depends on kdu_pkg, kdu_chan_if, kdu_keymap, kdu_diac, kdu_obuf.
//
// in_ch takes one item at a time: a keymap word write, a diacritic word
// write, or a key event. out_ch gives the UTF-8 bytes of a key event,
// last_byte marking the final one; events that produce nothing give no item.
// A write is done in the cycle it is accepted. A key event passes keymap
// reads and checks through one registered memory port (LK1, LK2 for caps
// lock, NPAD, LK3 for num lock; fewer on an early exit), then, when a dead
// key is pending, a diacritic search one entry at a time through read and
// compare states (one shared compare), then appends up to eight bytes to
// the buffer and waits while out_ch drains before it returns to idle.
// in_ch.ready is high only between events.
// After reset a clearing pass over all MOD_PLANES x KEY_CODES keymap
// addresses (2048 at the defaults) zeroes the keymap and diacritic table;
// in_ch.ready stays low meanwhile and no pending dead key is held.
// If out_ch stalls, the byte waits in the output register and the block
// holds the event until the last byte is in the output register; the next
// item may be accepted while the last byte still waits.
`include "keymap_dead_key_utf8_translator_assert.svh"

module keymap_dead_key_utf8_translator #(
	parameter int DIACRITIC_ENTRIES = 64,
	parameter int KEY_CODES = 128
) (
	input logic         clk,
	input logic         arst_n,
	kdu_chan_if.sink    in_ch,
	kdu_chan_if.source  out_ch
);
	import kdu_pkg::*;

	localparam int KM_DEPTH = MOD_PLANES * KEY_CODES;
	localparam int KAW = $clog2(KM_DEPTH);
	localparam int DIW = (DIACRITIC_ENTRIES > 1) ? $clog2(DIACRITIC_ENTRIES) : 1;

	localparam logic [3:0] S_CLR   = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_LK1   = 4'd2;
	localparam logic [3:0] S_LK2   = 4'd3;
	localparam logic [3:0] S_NPAD  = 4'd4;
	localparam logic [3:0] S_LK3   = 4'd5;
	localparam logic [3:0] S_DEAD  = 4'd6;
	localparam logic [3:0] S_SRD   = 4'd7;
	localparam logic [3:0] S_SCMP  = 4'd8;
	localparam logic [3:0] S_APPA  = 4'd9;
	localparam logic [3:0] S_APPV  = 4'd10;
	localparam logic [3:0] S_START = 4'd11;
	localparam logic [3:0] S_WAIT  = 4'd12;

	logic [3:0]     state_q;
	logic [KAW-1:0] clr_q;
	logic [3:0]     plane_q;
	logic [6:0]     key_q;
	logic           caps_q;
	logic           num_q;
	logic [23:0]    value_q;
	logic [20:0]    pend_q;
	logic [20:0]    aux_q;
	logic [DIW-1:0] idx_q;

	logic           acc;
	logic           clearing;
	logic [3:0]     in_plane;
	logic [3:0]     km_rplane;
	logic [6:0]     km_rkey;
	logic [KAW-1:0] km_raddr;
	logic [23:0]    km_rdata;
	logic           km_we;
	logic [KAW-1:0] km_waddr;
	logic [23:0]    km_wdata;
	logic           dia_we;
	logic [DIW-1:0] dia_waddr;
	logic [20:0]    dia_wdata;
	kdu_dia_row_t   dia_rdata;
	kdu_obuf_ctl_t  ob_ctl;
	logic           ob_busy;
	logic           dia_hit;
	logic           dia_end;

	assign in_ch.ready = (state_q == S_IDLE);
	assign acc         = in_ch.valid && in_ch.ready;
	assign clearing    = (state_q == S_CLR);
	assign in_plane    = {in_ch.data.alt_down, in_ch.data.altgr_down,
		in_ch.data.ctrl_down, in_ch.data.shift_down};

	always_comb begin
		case (state_q)
			S_IDLE:  km_rplane = in_plane;
			S_LK1:   km_rplane = plane_q ^ PL_SHIFT;
			S_NPAD:  km_rplane = PL_SHIFT;
			default: km_rplane = plane_q;
		endcase
	end

	assign km_rkey  = (state_q == S_IDLE) ? in_ch.data.key_code : key_q;
	assign km_raddr = KAW'(km_rplane) * KAW'(KEY_CODES) + KAW'(km_rkey);

	assign km_we    = clearing || (acc && in_ch.data.kind == KIND_MAP);
	assign km_waddr = clearing ? clr_q :
		KAW'(in_ch.data.table_plane) * KAW'(KEY_CODES) + KAW'(in_ch.data.table_slot);
	assign km_wdata = clearing ? '0 : in_ch.data.table_word;

	assign dia_we = (clearing && clr_q < KAW'(DIACRITIC_ENTRIES)) ||
		(acc && in_ch.data.kind == KIND_DIA && in_ch.data.table_plane <= 4'(COL_RES) &&
		9'(in_ch.data.table_slot) < 9'(DIACRITIC_ENTRIES));
	assign dia_waddr = clearing ? clr_q[DIW-1:0] : DIW'(in_ch.data.table_slot);
	assign dia_wdata = clearing ? '0 : in_ch.data.table_word[20:0];

	assign dia_hit = (dia_rdata.dead == aux_q) && (dia_rdata.base == value_q[20:0]);
	assign dia_end = (dia_rdata.dead == '0) || (dia_rdata.base == '0);

	assign ob_ctl.clr   = acc;
	assign ob_ctl.app   = (state_q == S_APPA) || (state_q == S_APPV);
	assign ob_ctl.start = (state_q == S_START);
	assign ob_ctl.cp    = (state_q == S_APPA) ? aux_q : value_q[20:0];

	kdu_keymap #(.DEPTH(KM_DEPTH)) u_keymap (
		.clk   (clk),
		.we    (km_we),
		.waddr (km_waddr),
		.wdata (km_wdata),
		.raddr (km_raddr),
		.rdata (km_rdata)
	);

	kdu_diac #(.ENTRIES(DIACRITIC_ENTRIES)) u_diac (
		.clk   (clk),
		.we    (dia_we),
		.wall  (clearing),
		.wcol  (in_ch.data.table_plane[1:0]),
		.waddr (dia_waddr),
		.wdata (dia_wdata),
		.raddr (idx_q),
		.rdata (dia_rdata)
	);

	kdu_obuf u_obuf (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ob_ctl),
		.busy   (ob_busy),
		.out_ch (out_ch)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q   <= '0;
			pend_q  <= '0;
			plane_q <= '0;
			key_q   <= '0;
			caps_q  <= 1'b0;
			num_q   <= 1'b0;
			value_q <= '0;
			aux_q   <= '0;
			idx_q   <= '0;
		end else begin
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + KAW'(1);
					if (clr_q == KAW'(KM_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (acc && in_ch.data.kind == KIND_KEY && !in_ch.data.released) begin
						plane_q <= in_plane;
						key_q   <= in_ch.data.key_code;
						caps_q  <= in_ch.data.caps_lock_on;
						num_q   <= in_ch.data.num_lock_on;
						state_q <= S_LK1;
					end
				end
				S_LK1: begin
					if (km_rdata == '0) begin
						state_q <= S_IDLE;
					end else if (km_rdata[BIT_CAPS] && caps_q) begin
						plane_q <= plane_q ^ PL_SHIFT;
						state_q <= S_LK2;
					end else begin
						value_q <= km_rdata;
						state_q <= S_NPAD;
					end
				end
				S_LK2: begin
					value_q <= km_rdata;
					state_q <= (km_rdata == '0) ? S_IDLE : S_NPAD;
				end
				S_NPAD: begin
					if (!value_q[BIT_NPAD]) begin
						state_q <= S_DEAD;
					end else if (plane_q[0]) begin
						state_q <= S_IDLE;
					end else if (num_q) begin
						state_q <= S_LK3;
					end else begin
						state_q <= S_DEAD;
					end
				end
				S_LK3: begin
					value_q <= km_rdata;
					state_q <= (km_rdata == '0) ? S_IDLE : S_DEAD;
				end
				S_DEAD: begin
					if (value_q[BIT_DEAD]) begin
						if (pend_q == '0) begin
							pend_q  <= value_q[20:0];
							state_q <= S_IDLE;
						end else begin
							aux_q   <= pend_q;
							pend_q  <= '0;
							state_q <= S_APPA;
						end
					end else if (pend_q != '0) begin
						aux_q  <= pend_q;
						pend_q <= '0;
						if (value_q[20:0] == CP_SPACE) begin
							value_q[20:0] <= pend_q;
							state_q       <= S_APPV;
						end else begin
							idx_q   <= '0;
							state_q <= S_SRD;
						end
					end else begin
						state_q <= S_APPV;
					end
				end
				S_SRD: begin
					state_q <= S_SCMP;
				end
				S_SCMP: begin
					if (dia_end) begin
						state_q <= S_APPA;
					end else if (dia_hit) begin
						value_q[20:0] <= dia_rdata.res;
						state_q       <= S_APPV;
					end else if (idx_q == DIW'(DIACRITIC_ENTRIES - 1)) begin
						state_q <= S_APPA;
					end else begin
						idx_q   <= idx_q + DIW'(1);
						state_q <= S_SRD;
					end
				end
				S_APPA: begin
					state_q <= S_APPV;
				end
				S_APPV: begin
					state_q <= S_START;
				end
				S_START: begin
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (!ob_busy) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`KDU_ASSERT_NOW(a_clr_quiet, clk, arst_n, state_q == S_CLR, !out_ch.valid,
		"output during table clear")
	`KDU_ASSERT_NEXT(a_pend_taken, clk, arst_n, state_q == S_DEAD && pend_q != '0,
		pend_q == '0, "pending dead key not consumed")
	`KDU_ASSERT_NEXT(a_search_step, clk, arst_n, state_q == S_SCMP,
		state_q == S_SRD || state_q == S_APPA || state_q == S_APPV,
		"diacritic search left badly")
endmodule
